// File: sv/fcma_pkg.sv
package fcma_pkg;

   localparam int WINDOW_DEPTH  = 16;
   localparam int AVERAGE_SHIFT = 4;

   localparam int NUM_CHANNELS  = 4;
   localparam int SAMPLE_WIDTH  = 12;
   localparam int CHANNEL_WIDTH = 2;
   localparam int AVERAGE_MAX   = 4095;

   // the largest window sum is WINDOW_DEPTH full-scale samples
   localparam int SUM_MAX   = WINDOW_DEPTH * AVERAGE_MAX;
   localparam int SUM_WIDTH = $clog2(SUM_MAX + 1);

   typedef logic [SAMPLE_WIDTH-1:0]  sample_type;
   typedef logic [SUM_WIDTH-1:0]     sum_type;
   typedef logic [CHANNEL_WIDTH-1:0] channel_type;

   // channel codes of report_channel
   localparam channel_type CH_MOTOR_TEMP = 2'd0;
   localparam channel_type CH_AMP_TEMP   = 2'd1;
   localparam channel_type CH_CURRENT_A  = 2'd2;
   localparam channel_type CH_CURRENT_B  = 2'd3;

endpackage

// File: sv/four_channel_moving_average_core.sv
// Four-channel boxcar moving average.
// Input channel (req_): one transfer carries a scan of four 12-bit samples
// (motor temperature, amplifier temperature, phase current A, phase current B)
// and the code of the channel whose average is wanted.
// Result channel (rsp_): one transfer per scan, rsp_report_average, the
// running window sum of the requested channel after this scan is added,
// shifted right by AVERAGE_SHIFT and clipped to 4095.
// Each channel keeps the last WINDOW_DEPTH samples in a shift line of
// registers and a running sum (add the new sample, drop the oldest).
// A scan passes the input register and then the result register before its
// result shows on rsp_.
// Throughput: one scan per cycle while rsp_stall is low; the sum update is a
// single add/subtract between the input register and the result register.
// Reset clears the sample lines, the sums and both valid flags;
// the window then covers only the scans taken since reset.
// When the receiver raises rsp_stall the result register holds its value,
// one more scan can still wait in the input register, and after that
// req_stall goes high until the result is taken.
module four_channel_moving_average_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fcma_pkg::sample_type        req_motor_temp_sample,
   input  fcma_pkg::sample_type        req_amp_temp_sample,
   input  fcma_pkg::sample_type        req_current_a_sample,
   input  fcma_pkg::sample_type        req_current_b_sample,
   input  fcma_pkg::channel_type       req_report_channel,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fcma_pkg::sample_type        rsp_report_average
);

   localparam int NCH   = fcma_pkg::NUM_CHANNELS;
   localparam int DEPTH = fcma_pkg::WINDOW_DEPTH;

   logic                  req_accept;
   logic                  s1_advance;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   fcma_pkg::sample_type  s1_sample_ff [NCH];
   fcma_pkg::channel_type s1_channel_ff;

   fcma_pkg::sample_type  line_ff [NCH][DEPTH];
   fcma_pkg::sum_type     sum_ff  [NCH];
   fcma_pkg::sum_type     sum_in  [NCH];

   fcma_pkg::sum_type     shifted_sum;
   fcma_pkg::sample_type  average_in;
   fcma_pkg::sample_type  average_ff;

   // result register moves when empty or being taken
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         // oldest sample leaves the window as the new one enters
         sum_in[c] = sum_ff[c] - fcma_pkg::sum_type'(line_ff[c][DEPTH-1])
                               + fcma_pkg::sum_type'(s1_sample_ff[c]);
      end
      shifted_sum = sum_in[s1_channel_ff] >> fcma_pkg::AVERAGE_SHIFT;
      if (shifted_sum > fcma_pkg::sum_type'(fcma_pkg::AVERAGE_MAX)) begin
         average_in = fcma_pkg::sample_type'(fcma_pkg::AVERAGE_MAX);
      end else begin
         average_in = shifted_sum[fcma_pkg::SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff[fcma_pkg::CH_MOTOR_TEMP] <= req_motor_temp_sample;
         s1_sample_ff[fcma_pkg::CH_AMP_TEMP]   <= req_amp_temp_sample;
         s1_sample_ff[fcma_pkg::CH_CURRENT_A]  <= req_current_a_sample;
         s1_sample_ff[fcma_pkg::CH_CURRENT_B]  <= req_current_b_sample;
         s1_channel_ff                         <= req_report_channel;
      end
      if (s1_advance) begin
         average_ff <= average_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            sum_ff[c] <= '0;
            for (int k = 0; k < DEPTH; k++) begin
               line_ff[c][k] <= '0;
            end
         end
      end else if (s1_advance) begin
         for (int c = 0; c < NCH; c++) begin
            sum_ff[c]     <= sum_in[c];
            line_ff[c][0] <= s1_sample_ff[c];
            for (int k = 1; k < DEPTH; k++) begin
               line_ff[c][k] <= line_ff[c][k-1];
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_report_average = average_ff;

   // a scan is never taken while the input register is full and blocked
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && s1_valid_ff && !s1_advance))
      else $error("input register overrun");

   // a new result only appears after a scan sat in the input register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a scan");

   // the window sums stay within the reachable range
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff[0] <= fcma_pkg::sum_type'(fcma_pkg::SUM_MAX) &&
      sum_ff[1] <= fcma_pkg::sum_type'(fcma_pkg::SUM_MAX) &&
      sum_ff[2] <= fcma_pkg::sum_type'(fcma_pkg::SUM_MAX) &&
      sum_ff[3] <= fcma_pkg::sum_type'(fcma_pkg::SUM_MAX))
      else $error("window sum out of range");

   // sums only change when a scan moves to the result register
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(sum_ff[0]) && $stable(sum_ff[1]) &&
                      $stable(sum_ff[2]) && $stable(sum_ff[3]))
      else $error("window sum changed without a scan");

endmodule
